/* rtl/cq_pkg.sv */
package cq_pkg;

    localparam int DATA_W   = 32;
    localparam int CAP_W    = 5;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PEEK = 2'd2,
        OP_SHOW = 2'd3
    } op_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SHOW
    } back_state_t;

    // One classified command as it travels from the front part to the back part.
    typedef struct packed {
        op_kind_t          kind;
        logic [DATA_W-1:0] value;
    } cmd_t;

endpackage

/* rtl/cq_front.sv */
module cq_front
    import cq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]   s_tuser,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cmd_t              cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    cmd_t       in_cmd;

    // Decode the operation code into a command kind.
    always_comb begin
        in_cmd.value = s_tdata;
        in_cmd.kind  = op_kind_t'(s_tuser);
    end

    assign s_tready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* rtl/cq_back.sv */
module cq_back
    import cq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr,
    input  logic [CAP_W-1:0]    cfg_cap,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  cmd_t                cmd,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,
    output logic [STATUS_W-1:0] m_tuser,
    output logic                m_tlast
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [IDX_W-1:0]  tail_reg;
    logic [IDX_W-1:0]  tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  walk_reg;
    logic [IDX_W-1:0]  walk_next;
    logic [CNT_W-1:0]  remain_reg;
    logic [CNT_W-1:0]  remain_next;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_empty_reg;
    logic              out_full_reg;

    logic [CNT_W-1:0]  cap_eff;
    logic              out_free;
    logic              q_empty;
    logic              q_full;
    logic              mem_we;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic              load;
    status_t           ld_status;
    logic [DATA_W-1:0] ld_data;
    logic              ld_last;

    function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i,
                                             input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] n;
        n = (CNT_W + 1)'(i) + (CNT_W + 1)'(1);
        return (n >= {1'b0, cap}) ? '0 : IDX_W'(n);
    endfunction

    // A capacity of zero acts as one, anything above the depth acts as the depth.
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (int'(cap_reg) > DEPTH) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign q_empty  = (count_reg == '0);
    assign q_full   = (count_reg >= cap_eff);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid && out_free && !q_empty) begin
                    if (cmd.kind == OP_DEQ || cmd.kind == OP_PEEK) begin
                        state_next = BK_READ;
                    end else if (cmd.kind == OP_SHOW) begin
                        state_next = BK_SHOW;
                    end
                end
            end
            BK_READ: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            BK_SHOW: begin
                if (out_free && remain_reg == CNT_W'(1)) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        cmd_ready   = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = head_reg;
        load        = 1'b0;
        ld_status   = ST_DONE;
        ld_data     = '0;
        ld_last     = 1'b1;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        walk_next   = walk_reg;
        remain_next = remain_reg;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready = 1'b1;
                    case (cmd.kind)
                        OP_ENQ: begin
                            load = 1'b1;
                            if (q_full) begin
                                ld_status = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                ld_data    = cmd.value;
                                tail_next  = nxt(tail_reg, cap_eff);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEQ: begin
                            if (q_empty) begin
                                load      = 1'b1;
                                ld_status = ST_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                head_next  = nxt(head_reg, cap_eff);
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_PEEK: begin
                            if (q_empty) begin
                                load      = 1'b1;
                                ld_status = ST_EMPTY;
                            end else begin
                                mem_re = 1'b1;
                            end
                        end
                        default: begin
                            if (q_empty) begin
                                load      = 1'b1;
                                ld_status = ST_EMPTY;
                            end else begin
                                mem_re      = 1'b1;
                                walk_next   = nxt(head_reg, cap_eff);
                                remain_next = count_reg;
                            end
                        end
                    endcase
                end
            end
            BK_READ: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_data = rd_data_reg;
                end
            end
            BK_SHOW: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_data = rd_data_reg;
                    ld_last = (remain_reg == CNT_W'(1));
                    if (remain_reg != CNT_W'(1)) begin
                        mem_re      = 1'b1;
                        mem_raddr   = walk_reg;
                        walk_next   = nxt(walk_reg, cap_eff);
                        remain_next = remain_reg - CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            walk_reg      <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            walk_reg   <= walk_next;
            remain_reg <= remain_next;
            if (cfg_wr) begin
                cap_reg   <= cfg_cap;
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
            end else begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_status_reg <= ld_status;
            out_data_reg   <= ld_data;
            out_last_reg   <= ld_last;
            out_empty_reg  <= (count_next == '0);
            out_full_reg   <= (count_next >= cap_eff);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[tail_reg] <= cmd.value;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_full_reg, out_empty_reg, out_data_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/circular_queue.sv */
// Circular FIFO of signed 32-bit words with a run-time capacity.
// Input beats arrive on the s_ channel: s_tuser carries the operation
// (enqueue, dequeue, peek, display) and s_tdata the word to enqueue.
// Result beats leave on the m_ channel: m_tuser carries the status (done,
// rejected as full, rejected as empty), m_tdata the word and the empty and
// full flags as they stand after the operation, and m_tlast marks the final
// beat that one input beat causes.
// A two-entry command queue separates the accepting front part from the
// executing back part, so input beats are taken while results wait.
// Enqueue and every rejected operation load the result register directly.
// Dequeue and peek first read the entry store, which has a registered read
// port, and load the result from it. Display reads the entries in turn and
// emits one beat per entry, front to rear.
// The cfg_ channel writes the capacity and also empties the queue; the user
// must write it only while the block is idle, as the block itself does not
// enforce this. Reset empties the queue and sets the capacity to 16. When the
// receiver stalls, the result register holds its beat, the back part waits,
// and the command queue fills before s_tready drops.
module circular_queue
    import cq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CAP_W-1:0]    cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]     s_tuser,   // [1:0] operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // [31:0] data, [32] is_empty, [33] is_full
    output logic [STATUS_W-1:0] m_tuser,   // [1:0] status
    output logic                m_tlast
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic cfg_wr;

    // The capacity register is always ready to take a write.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    cq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    cq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_wr),
        .cfg_cap   (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* bench/tb_circular_queue.sv */
module tb_circular_queue;
    import cq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    // Long enough for the longest display, which emits one beat per entry.
    localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;
    localparam int LONG_HOLD     = 60;
    localparam int TIMEOUT_UNITS = 2 * HALF_PERIOD * 400_000;

    // One result beat as the queue should produce it.
    typedef struct {
        status_t           status;
        logic [DATA_W-1:0] word;
        logic              last;
        logic              empty;
        logic              full;
    } queue_beat_t;

    // How the result side takes beats: always, at random, or on a fixed rhythm.
    typedef enum int {
        RX_STEADY,
        RX_RANDOM,
        RX_RHYTHM
    } rx_mode_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CAP_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;    // [31:0] value
    logic [OP_W-1:0]     s_tuser;    // [1:0] operation
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [39:0]         m_tdata;    // [31:0] data, [32] is_empty, [33] is_full
    logic [STATUS_W-1:0] m_tuser;    // [1:0] status
    logic                m_tlast;

    // Shadow of the queue, kept in step with every accepted beat.
    logic [DATA_W-1:0] shadow_store [QUEUE_DEPTH];
    logic [3:0]        shadow_head;
    logic [3:0]        shadow_tail;
    logic [4:0]        shadow_count;
    logic [CAP_W-1:0]  shadow_capacity;

    queue_beat_t due_beats [$];

    int error_count;
    int items_sent;
    int beats_checked;
    int full_rejects;
    int empty_rejects;
    int display_items;
    int capacity_writes;
    int input_stall_cycles;

    // Sender pacing: bursts of random length separated by random gaps.
    bit tx_bursty;
    int burst_left;

    // Receiver pacing, plus a request channel for a long hold-off.
    rx_mode_t rx_mode;
    int       hold_req_cycles;
    int       hold_req_id;

    circular_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // A register value of zero behaves as one entry; anything above the
    // built-in depth behaves as the full depth.
    function automatic int effective_capacity();
        if (shadow_capacity == 0) begin
            return 1;
        end
        if (shadow_capacity > QUEUE_DEPTH) begin
            return QUEUE_DEPTH;
        end
        return int'(shadow_capacity);
    endfunction

    // Indices wrap at the capacity in use, not at the physical depth.
    function automatic logic [3:0] next_slot(logic [3:0] slot, int cap);
        if (int'(slot) + 1 >= cap) begin
            return 4'd0;
        end
        return slot + 4'd1;
    endfunction

    // The flags reflect the queue after the operation, so this is called
    // once the shadow state has been updated.
    function automatic void add_due_beat(status_t st, logic [DATA_W-1:0] word, logic last);
        queue_beat_t beat;
        beat.status = st;
        beat.word   = word;
        beat.last   = last;
        beat.empty  = (shadow_count == 0);
        beat.full   = (int'(shadow_count) >= effective_capacity());
        due_beats.push_back(beat);
    endfunction

    // Applies one accepted operation to the shadow queue and queues up the
    // beats it must produce. A capacity write always clears the indices, so
    // head and tail never sit beyond the capacity in use.
    function automatic void apply_queue_op(op_kind_t op, logic [DATA_W-1:0] word);
        int         cap;
        int         n;
        logic [3:0] slot;
        cap = effective_capacity();
        case (op)
            OP_ENQ: begin
                if (int'(shadow_count) >= cap) begin
                    full_rejects++;
                    add_due_beat(ST_FULL, '0, 1'b1);
                end else begin
                    shadow_store[shadow_tail] = word;
                    shadow_tail  = next_slot(shadow_tail, cap);
                    shadow_count = shadow_count + 5'd1;
                    add_due_beat(ST_DONE, word, 1'b1);
                end
            end
            OP_DEQ: begin
                if (shadow_count == 0) begin
                    empty_rejects++;
                    add_due_beat(ST_EMPTY, '0, 1'b1);
                end else begin
                    slot         = shadow_head;
                    shadow_head  = next_slot(shadow_head, cap);
                    shadow_count = shadow_count - 5'd1;
                    add_due_beat(ST_DONE, shadow_store[slot], 1'b1);
                end
            end
            OP_PEEK: begin
                if (shadow_count == 0) begin
                    empty_rejects++;
                    add_due_beat(ST_EMPTY, '0, 1'b1);
                end else begin
                    add_due_beat(ST_DONE, shadow_store[shadow_head], 1'b1);
                end
            end
            default: begin
                display_items++;
                if (shadow_count == 0) begin
                    empty_rejects++;
                    add_due_beat(ST_EMPTY, '0, 1'b1);
                end else begin
                    // One beat per entry, front to rear; only the rear is last.
                    slot = shadow_head;
                    for (n = 0; n < int'(shadow_count); n++) begin
                        add_due_beat(ST_DONE, shadow_store[slot],
                                     (n + 1 == int'(shadow_count)));
                        slot = next_slot(slot, cap);
                    end
                end
            end
        endcase
    endfunction

    // Result checking. Outputs are read right after the edge, before any
    // nonblocking update lands, so they are the values the edge saw.
    always @(posedge aclk) begin
        queue_beat_t want;
        if (aresetn && s_tvalid && !s_tready) begin
            input_stall_cycles++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (due_beats.size() == 0) begin
                $error("result beat with no beat due: status %0d data %0d last %0b",
                       m_tuser, $signed(m_tdata[31:0]), m_tlast);
                error_count++;
            end else begin
                want = due_beats.pop_front();
                beats_checked++;
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[31:0] !== want.word) begin
                    $error("data: expected %0d, got %0d",
                           $signed(want.word), $signed(m_tdata[31:0]));
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    error_count++;
                end
                if (m_tdata[32] !== want.empty) begin
                    $error("is_empty: expected %0b, got %0b", want.empty, m_tdata[32]);
                    error_count++;
                end
                if (m_tdata[33] !== want.full) begin
                    $error("is_full: expected %0b, got %0b", want.full, m_tdata[33]);
                    error_count++;
                end
            end
        end
    end

    // Receiver. A hold-off request takes priority and is counted down here;
    // otherwise m_tready follows the current mode.
    always @(posedge aclk) begin
        static int rhythm_count = 0;
        static int hold_left    = 0;
        static int hold_seen_id = 0;
        rhythm_count++;
        if (hold_req_id != hold_seen_id) begin
            hold_seen_id = hold_req_id;
            hold_left    = hold_req_cycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_RANDOM: m_tready <= ($urandom_range(0, 99) < 65);
                RX_RHYTHM: m_tready <= ((rhythm_count % 9) < 5);
                default:   m_tready <= 1'b1;
            endcase
        end
    end

    // Offers one beat and waits for it to be taken. Valid stays high after
    // acceptance unless a gap is due, so back-to-back beats need no toggle.
    task automatic send_item(op_kind_t op, logic [DATA_W-1:0] word);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        apply_queue_op(op, word);
        items_sent++;
        if (tx_bursty) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 7);
                burst_left = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stops offering and waits until every due beat has been seen, then lets
    // the block settle before anything else happens.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (due_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only called while the block is idle. The write also empties the queue.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_capacity = cap;
        shadow_head     = '0;
        shadow_tail     = '0;
        shadow_count    = '0;
        capacity_writes++;
    endtask

    // Mostly random words, with the signed extremes mixed in now and then.
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Enqueue with the given percentage; the rest is split among dequeue,
    // peek and display so the queue both fills and drains.
    task automatic send_random_item(int enq_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < enq_pct) begin
            send_item(OP_ENQ, pick_word());
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                send_item(OP_DEQ, $urandom);
            end else if (roll < 85) begin
                send_item(OP_PEEK, $urandom);
            end else begin
                send_item(OP_SHOW, $urandom);
            end
        end
    endtask

    // At the reset capacity: every operation on an empty queue, then the
    // signed extremes in and back out.
    task automatic test_empty_and_extremes();
        send_item(OP_PEEK, 32'h0);
        send_item(OP_DEQ, 32'hDEAD_BEEF);
        send_item(OP_SHOW, 32'h0);
        send_item(OP_ENQ, 32'h7FFF_FFFF);
        send_item(OP_ENQ, 32'h8000_0000);
        send_item(OP_ENQ, 32'h0000_0000);
        send_item(OP_ENQ, 32'hFFFF_FFFF);
        send_item(OP_PEEK, 32'h0);
        send_item(OP_SHOW, 32'h0);
        send_item(OP_DEQ, 32'h0);
        send_item(OP_DEQ, 32'h0);
        wait_drained();
    endtask

    // Zero acts as a capacity of one; a capacity of two forces the indices
    // to wrap and a display to cross the wrap point.
    task automatic test_small_capacities();
        write_capacity(5'd0);
        send_item(OP_ENQ, 32'h1234_5678);
        send_item(OP_ENQ, 32'h0BAD_F00D);
        send_item(OP_SHOW, 32'h0);
        send_item(OP_DEQ, 32'h0);
        send_item(OP_DEQ, 32'h0);
        wait_drained();
        write_capacity(5'd2);
        send_item(OP_ENQ, 32'hA5A5_A5A5);
        send_item(OP_ENQ, 32'h5A5A_5A5A);
        send_item(OP_ENQ, 32'hFFFF_0000);
        send_item(OP_DEQ, 32'h0);
        send_item(OP_ENQ, 32'h0000_FFFF);
        send_item(OP_SHOW, 32'h0);
        send_item(OP_DEQ, 32'h0);
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while beats keep coming, so
    // the command queue fills and the input stalls. A full sixteen-entry
    // display gives the most beats one item can cause.
    task automatic test_backpressure();
        int i;
        write_capacity(5'd16);
        tx_bursty = 1'b0;
        hold_req_cycles <= LONG_HOLD;
        hold_req_id     <= hold_req_id + 1;
        for (i = 0; i < QUEUE_DEPTH; i++) begin
            send_item(OP_ENQ, pick_word());
        end
        send_item(OP_SHOW, 32'h0);
        send_item(OP_PEEK, 32'h0);
        send_item(OP_DEQ, 32'h0);
        send_item(OP_DEQ, 32'h0);
        wait_drained();
        tx_bursty = 1'b1;
    endtask

    // Several capacity settings, including the top of the register range, a
    // capacity of one and a random one. The enqueue share swings between high and low so the
    // queue keeps running into full and back into empty. One setting runs
    // with no idling on either side.
    task automatic test_random_traffic();
        logic [CAP_W-1:0] caps [6];
        int k;
        int i;
        caps = '{5'd31, 5'd1, 5'd5, 5'd16, 5'd9, 5'd3};
        caps[4] = CAP_W'($urandom_range(2, 15));
        for (k = 0; k < 6; k++) begin
            write_capacity(caps[k]);
            case (k % 3)
                0:       rx_mode = RX_STEADY;
                1:       rx_mode = RX_RANDOM;
                default: rx_mode = RX_RHYTHM;
            endcase
            tx_bursty = (k != 3);
            for (i = 0; i < 45; i++) begin
                send_random_item(((i / 10) % 2 == 0) ? 70 : 30);
            end
            wait_drained();
        end
        rx_mode   = RX_RANDOM;
        tx_bursty = 1'b1;
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_ENQ;
        hold_req_cycles = 0;
        hold_req_id     = 0;
        rx_mode    = RX_RANDOM;
        tx_bursty  = 1'b1;
        burst_left = 0;
        shadow_capacity = CAP_RESET;
        shadow_head     = '0;
        shadow_tail     = '0;
        shadow_count    = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_and_extremes();
        test_small_capacities();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        if (due_beats.size() != 0) begin
            $error("%0d result beats never arrived", due_beats.size());
            error_count++;
        end

        $display("Run covered %0d operations (%0d displays, %0d full and %0d empty rejections),",
                 items_sent, display_items, full_rejects, empty_rejects);
        $display("%0d checked result beats, %0d capacity writes, %0d input stall cycles.",
                 beats_checked, capacity_writes, input_stall_cycles);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_UNITS;
        $display("Some tests failed");
        $finish;
    end

endmodule
